### rtl/pfsm_pkg.sv
// ============================================================================
// pfsm_pkg
// Types and codes shared by the parent failover controller.
// ============================================================================
package pfsm_pkg;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DOWN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ELIG_DELAY  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PREF_TMO    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STABILIZE   = CFG_IDX_W'(3);

    localparam logic [31:0] HOLD_DOWN_RST  = 32'd30000;
    localparam logic [31:0] ELIG_DELAY_RST = 32'd10000;
    localparam logic [31:0] PREF_TMO_RST   = 32'd15000;
    localparam logic [31:0] STABILIZE_RST  = 32'd30000;

    localparam logic [15:0] NO_ADDR     = 16'hffff;
    localparam logic [15:0] ALT_NO_ADDR = 16'hfffe;

    typedef enum logic [3:0] {
        M_BOOT   = 4'd0,
        M_ATTACH = 4'd1,
        M_NOSTBY = 4'd2,
        M_WARM   = 4'd3,
        M_ELIG   = 4'd4,
        M_TRIG   = 4'd5,
        M_PREF   = 4'd6,
        M_GEN    = 4'd7,
        M_STAB   = 4'd8
    } mode_t;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PREF    = 2'd1;
    localparam logic [1:0] KIND_GENERIC = 2'd2;

    localparam logic [1:0] RSN_NONE       = 2'd0;
    localparam logic [1:0] RSN_NO_STANDBY = 2'd1;
    localparam logic [1:0] RSN_PREF_MISS  = 2'd2;
    localparam logic [1:0] RSN_PREF_TMO   = 2'd3;

    localparam logic [1:0] OC_NONE    = 2'd0;
    localparam logic [1:0] OC_SUCCESS = 2'd1;
    localparam logic [1:0] OC_MISS    = 2'd2;
    localparam logic [1:0] OC_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        attached_child;
        logic        standby_ok;
        logic        health_fail;
        logic        health_degrade;
        logic [15:0] attached_parent;
        logic [15:0] standby_parent;
    } in_t;

    typedef struct packed {
        logic [1:0]  action_kind;
        logic [1:0]  action_reason;
        logic [15:0] action_target;
        logic [15:0] action_parent;
        logic [3:0]  state_now;
        logic [31:0] failovers_done;
        logic [31:0] preferred_attempts;
        logic [31:0] preferred_successes;
        logic [31:0] preferred_misses;
        logic [1:0]  last_outcome;
        logic [15:0] last_target;
        logic [31:0] outcome_events;
    } out_t;

endpackage

### rtl/parent_failover_state_machine_top.sv
// ============================================================================
// parent_failover_state_machine_top
// Parent failover controller: one evaluation beat in, one result beat out.
// ============================================================================
//
//  channel | ports                              | direction | payload
//  --------+------------------------------------+-----------+------------------
//  input   | s_valid  s_ready  s_data           | in        | in_t event
//  result  | m_valid  m_ready  m_data           | out       | out_t result
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in    | 32-bit register
//
//  Two register stages: an input register and a result register, with the
//  whole mode/counter update as combinational logic between them. One beat
//  per cycle sustained while the result channel is not stalled.
//  A stalled result holds the result register; the input register keeps
//  taking a beat while it is empty or moving on. Reset (aresetn low,
//  synchronous) empties both stages and restores modes, counters and config
//  registers. Config writes are always taken (cfg_ready high); unknown
//  indices are dropped.
//
module parent_failover_state_machine_top
    import pfsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // ---- configuration registers ----
    logic [31:0] hold_down_reg, elig_delay_reg, pref_tmo_reg, stabilize_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_down_reg  <= HOLD_DOWN_RST;
            elig_delay_reg <= ELIG_DELAY_RST;
            pref_tmo_reg   <= PREF_TMO_RST;
            stabilize_reg  <= STABILIZE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HOLD_DOWN:  hold_down_reg  <= cfg_data;
                REG_ELIG_DELAY: elig_delay_reg <= cfg_data;
                REG_PREF_TMO:   pref_tmo_reg   <= cfg_data;
                REG_STABILIZE:  stabilize_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- pipeline handshake ----
    logic in_valid_reg;
    in_t  in_reg;
    logic advance;     // evaluation stage retires its beat into the result reg

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // ---- controller state ----
    mode_t       mode_reg, mode_next;
    logic [31:0] entered_at_reg, entered_at_next;
    logic [31:0] last_fo_reg, last_fo_next;
    logic [31:0] elig_since_reg, elig_since_next;
    logic [15:0] cur_target_reg, cur_target_next;
    logic [31:0] fo_tally_reg, fo_tally_next;
    logic [31:0] att_tally_reg, att_tally_next;
    logic [31:0] succ_tally_reg, succ_tally_next;
    logic [31:0] miss_tally_reg, miss_tally_next;
    logic [1:0]  oc_code_reg, oc_code_next;
    logic [15:0] oc_target_reg, oc_target_next;
    logic [31:0] oc_tally_reg, oc_tally_next;

    // interval checks, all modulo 2^32
    logic [31:0] now;
    logic        att, sb, hf, hd, known, par_match;
    logic        hold_over, elig_over, pref_over, stab_over;

    assign now       = in_reg.now_ms;
    assign att       = in_reg.attached_child;
    assign sb        = in_reg.standby_ok;
    assign hf        = in_reg.health_fail;
    assign hd        = in_reg.health_degrade;
    assign known     = (in_reg.attached_parent != NO_ADDR) &&
                       (in_reg.attached_parent != ALT_NO_ADDR);
    assign par_match = (in_reg.attached_parent == cur_target_reg);
    assign hold_over = (now - last_fo_reg)    >= hold_down_reg;
    assign elig_over = (now - elig_since_reg) >= elig_delay_reg;
    assign pref_over = (now - entered_at_reg) >= pref_tmo_reg;
    assign stab_over = (now - entered_at_reg) >= stabilize_reg;

    // next mode
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            M_BOOT:   mode_next = M_ATTACH;
            M_ATTACH: if (att) mode_next = sb ? M_WARM : M_NOSTBY;
            M_NOSTBY: begin
                if (!att)                  mode_next = M_ATTACH;
                else if (sb)               mode_next = M_WARM;
                else if (hf && hold_over)  mode_next = M_TRIG;
            end
            M_WARM: begin
                if (!att)                  mode_next = M_ATTACH;
                else if (!sb)              mode_next = M_NOSTBY;
                else if (hf && hold_over)  mode_next = M_TRIG;
                else if (hd && hold_over)  mode_next = M_ELIG;
            end
            M_ELIG: begin
                if (!att)                  mode_next = M_ATTACH;
                else if (!hd)              mode_next = sb ? M_WARM : M_NOSTBY;
                else if (elig_over)        mode_next = M_TRIG;
            end
            M_TRIG:   mode_next = sb ? M_PREF : M_GEN;
            M_PREF: begin
                if (att && known && par_match) mode_next = M_STAB;
                else if (att && known)         mode_next = M_GEN;
                else if (pref_over)            mode_next = M_GEN;
            end
            M_GEN:    if (att) mode_next = M_STAB;
            M_STAB: begin
                if (!att)                  mode_next = M_ATTACH;
                else if (stab_over)        mode_next = sb ? M_WARM : M_NOSTBY;
            end
            default:  mode_next = M_BOOT;
        endcase
    end

    // action, counters and stamps
    logic [1:0]  kind, reason;
    logic [15:0] atarget, aparent;

    always_comb begin
        kind            = KIND_NONE;
        reason          = RSN_NONE;
        atarget         = NO_ADDR;
        aparent         = NO_ADDR;
        entered_at_next = entered_at_reg;
        last_fo_next    = last_fo_reg;
        elig_since_next = elig_since_reg;
        cur_target_next = cur_target_reg;
        fo_tally_next   = fo_tally_reg;
        att_tally_next  = att_tally_reg;
        succ_tally_next = succ_tally_reg;
        miss_tally_next = miss_tally_reg;
        oc_code_next    = oc_code_reg;
        oc_target_next  = oc_target_reg;
        oc_tally_next   = oc_tally_reg;

        // every real mode change restamps the entry time
        if (mode_next != mode_reg) entered_at_next = now;

        unique case (mode_reg)
            M_WARM: if (mode_next == M_ELIG) elig_since_next = now;
            M_TRIG: begin
                if (sb) begin
                    att_tally_next  = att_tally_reg + 32'd1;
                    cur_target_next = in_reg.standby_parent;
                    kind            = KIND_PREF;
                    atarget         = in_reg.standby_parent;
                end else begin
                    kind   = KIND_GENERIC;
                    reason = RSN_NO_STANDBY;
                end
            end
            M_PREF: begin
                if (att && known && par_match) begin
                    last_fo_next    = now;
                    fo_tally_next   = fo_tally_reg + 32'd1;
                    succ_tally_next = succ_tally_reg + 32'd1;
                    oc_code_next    = OC_SUCCESS;
                    oc_target_next  = cur_target_reg;
                    oc_tally_next   = oc_tally_reg + 32'd1;
                    cur_target_next = NO_ADDR;
                end else if ((att && known) || pref_over) begin
                    // miss, or timeout (a timeout while attached counts as a miss)
                    miss_tally_next = miss_tally_reg + 32'd1;
                    oc_target_next  = cur_target_reg;
                    oc_tally_next   = oc_tally_reg + 32'd1;
                    kind            = KIND_GENERIC;
                    atarget         = cur_target_reg;
                    cur_target_next = NO_ADDR;
                    if (att && known) begin
                        aparent = in_reg.attached_parent;
                    end
                    if (!att) begin
                        oc_code_next = OC_TIMEOUT;
                        reason       = RSN_PREF_TMO;
                    end else begin
                        oc_code_next = OC_MISS;
                        reason       = RSN_PREF_MISS;
                    end
                end
            end
            M_GEN: begin
                if (att) begin
                    last_fo_next  = now;
                    fo_tally_next = fo_tally_reg + 32'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_BOOT;
            entered_at_reg <= '0;
            last_fo_reg    <= '0;
            elig_since_reg <= '0;
            cur_target_reg <= NO_ADDR;
            fo_tally_reg   <= '0;
            att_tally_reg  <= '0;
            succ_tally_reg <= '0;
            miss_tally_reg <= '0;
            oc_code_reg    <= OC_NONE;
            oc_target_reg  <= NO_ADDR;
            oc_tally_reg   <= '0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            entered_at_reg <= entered_at_next;
            last_fo_reg    <= last_fo_next;
            elig_since_reg <= elig_since_next;
            cur_target_reg <= cur_target_next;
            fo_tally_reg   <= fo_tally_next;
            att_tally_reg  <= att_tally_next;
            succ_tally_reg <= succ_tally_next;
            miss_tally_reg <= miss_tally_next;
            oc_code_reg    <= oc_code_next;
            oc_target_reg  <= oc_target_next;
            oc_tally_reg   <= oc_tally_next;
        end
    end

    // ---- result register ----
    out_t res_next;

    always_comb begin
        res_next.action_kind         = kind;
        res_next.action_reason       = reason;
        res_next.action_target       = atarget;
        res_next.action_parent       = aparent;
        res_next.state_now           = mode_next;
        res_next.failovers_done      = fo_tally_next;
        res_next.preferred_attempts  = att_tally_next;
        res_next.preferred_successes = succ_tally_next;
        res_next.preferred_misses    = miss_tally_next;
        res_next.last_outcome        = oc_code_next;
        res_next.last_target         = oc_target_next;
        res_next.outcome_events      = oc_tally_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data <= res_next;
        end
    end

endmodule

### tb/sv/pfsm_result_checker.sv
// ============================================================================
// pfsm_result_checker
// Watches the event, result and register channels of the parent failover
// controller. Keeps its own copy of the controller, predicts one result per
// accepted event and compares every result beat with the oldest prediction.
// ============================================================================
module pfsm_result_checker
    import pfsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_t                  s_data,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_t                 m_data,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    output int unsigned          fail_count,
    output int unsigned          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // interval registers
    logic [31:0] hold_down_ms;
    logic [31:0] eligible_delay_ms;
    logic [31:0] preferred_timeout_ms;
    logic [31:0] stabilize_ms;

    // controller state
    mode_t       ctl_mode;
    logic [31:0] entered_at;
    logic [31:0] last_failover_at;
    logic [31:0] eligible_since;
    logic [15:0] current_target;
    logic [31:0] failover_cnt;
    logic [31:0] attempt_cnt;
    logic [31:0] success_cnt;
    logic [31:0] miss_cnt;
    logic [1:0]  outcome_code;
    logic [15:0] outcome_target;
    logic [31:0] outcome_cnt;

    out_t        expected_results[$];
    int unsigned mismatches = 0;

    function automatic void move_to(input mode_t nxt, input logic [31:0] now);
        ctl_mode   = nxt;
        entered_at = now;
    endfunction

    function automatic void record_outcome(input logic [1:0] code, input logic [15:0] tgt);
        outcome_code   = code;
        outcome_target = tgt;
        outcome_cnt    = outcome_cnt + 32'd1;
    endfunction

    function automatic logic hold_down_over(input logic [31:0] now);
        logic [31:0] gap;
        gap = now - last_failover_at;
        return gap >= hold_down_ms;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // One evaluation event through the controller.
    task automatic advance_controller(input in_t ev, output out_t res);
        logic [31:0] now;
        logic [31:0] gap;
        logic        known;
        logic [1:0]  kind;
        logic [1:0]  reason;
        logic [15:0] a_tgt;
        logic [15:0] a_par;
        now    = ev.now_ms;
        gap    = now - entered_at;
        known  = (ev.attached_parent != NO_ADDR) && (ev.attached_parent != ALT_NO_ADDR);
        kind   = KIND_NONE;
        reason = RSN_NONE;
        a_tgt  = NO_ADDR;
        a_par  = NO_ADDR;
        case (ctl_mode)
            M_BOOT: move_to(M_ATTACH, now);
            M_ATTACH: begin
                if (ev.attached_child)
                    move_to(ev.standby_ok ? M_WARM : M_NOSTBY, now);
            end
            M_NOSTBY: begin
                if (!ev.attached_child)
                    move_to(M_ATTACH, now);
                else if (ev.standby_ok)
                    move_to(M_WARM, now);
                else if (ev.health_fail && hold_down_over(now))
                    move_to(M_TRIG, now);
            end
            M_WARM: begin
                if (!ev.attached_child)
                    move_to(M_ATTACH, now);
                else if (!ev.standby_ok)
                    move_to(M_NOSTBY, now);
                else if (ev.health_fail && hold_down_over(now))
                    move_to(M_TRIG, now);
                else if (ev.health_degrade && hold_down_over(now)) begin
                    move_to(M_ELIG, now);
                    eligible_since = now;
                end
            end
            M_ELIG: begin
                if (!ev.attached_child)
                    move_to(M_ATTACH, now);
                else if (!ev.health_degrade)
                    move_to(ev.standby_ok ? M_WARM : M_NOSTBY, now);
                else if (32'(now - eligible_since) >= eligible_delay_ms)
                    move_to(M_TRIG, now);
            end
            M_TRIG: begin
                if (ev.standby_ok) begin
                    move_to(M_PREF, now);
                    attempt_cnt    = attempt_cnt + 32'd1;
                    current_target = ev.standby_parent;
                    kind           = KIND_PREF;
                    a_tgt          = current_target;
                end else begin
                    move_to(M_GEN, now);
                    kind   = KIND_GENERIC;
                    reason = RSN_NO_STANDBY;
                end
            end
            M_PREF: begin
                if (ev.attached_child && known && ev.attached_parent == current_target) begin
                    move_to(M_STAB, now);
                    last_failover_at = now;
                    failover_cnt     = failover_cnt + 32'd1;
                    success_cnt      = success_cnt + 32'd1;
                    record_outcome(OC_SUCCESS, current_target);
                    current_target = NO_ADDR;
                end else if (ev.attached_child && known) begin
                    move_to(M_GEN, now);
                    miss_cnt = miss_cnt + 32'd1;
                    record_outcome(OC_MISS, current_target);
                    kind           = KIND_GENERIC;
                    reason         = RSN_PREF_MISS;
                    a_tgt          = outcome_target;
                    a_par          = ev.attached_parent;
                    current_target = NO_ADDR;
                end else if (gap >= preferred_timeout_ms) begin
                    move_to(M_GEN, now);
                    miss_cnt = miss_cnt + 32'd1;
                    kind     = KIND_GENERIC;
                    a_tgt    = current_target;
                    // still attached, but to a parent nobody can name: a miss
                    if (!ev.attached_child) begin
                        record_outcome(OC_TIMEOUT, current_target);
                        reason = RSN_PREF_TMO;
                    end else begin
                        record_outcome(OC_MISS, current_target);
                        reason = RSN_PREF_MISS;
                    end
                    current_target = NO_ADDR;
                end
            end
            M_GEN: begin
                if (ev.attached_child) begin
                    move_to(M_STAB, now);
                    last_failover_at = now;
                    failover_cnt     = failover_cnt + 32'd1;
                end
            end
            M_STAB: begin
                if (!ev.attached_child)
                    move_to(M_ATTACH, now);
                else if (gap >= stabilize_ms)
                    move_to(ev.standby_ok ? M_WARM : M_NOSTBY, now);
            end
            default: ctl_mode = M_BOOT;
        endcase
        res.action_kind         = kind;
        res.action_reason       = reason;
        res.action_target       = a_tgt;
        res.action_parent       = a_par;
        res.state_now           = ctl_mode;
        res.failovers_done      = failover_cnt;
        res.preferred_attempts  = attempt_cnt;
        res.preferred_successes = success_cnt;
        res.preferred_misses    = miss_cnt;
        res.last_outcome        = outcome_code;
        res.last_target         = outcome_target;
        res.outcome_events      = outcome_cnt;
    endtask

    always @(posedge aclk) begin
        out_t want;
        out_t got;
        if (!aresetn) begin
            hold_down_ms         = HOLD_DOWN_RST;
            eligible_delay_ms    = ELIG_DELAY_RST;
            preferred_timeout_ms = PREF_TMO_RST;
            stabilize_ms         = STABILIZE_RST;
            ctl_mode             = M_BOOT;
            entered_at           = '0;
            last_failover_at     = '0;
            eligible_since       = '0;
            current_target       = NO_ADDR;
            failover_cnt         = '0;
            attempt_cnt          = '0;
            success_cnt          = '0;
            miss_cnt             = '0;
            outcome_code         = OC_NONE;
            outcome_target       = NO_ADDR;
            outcome_cnt          = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HOLD_DOWN:  hold_down_ms         = cfg_data;
                    REG_ELIG_DELAY: eligible_delay_ms    = cfg_data;
                    REG_PREF_TMO:   preferred_timeout_ms = cfg_data;
                    REG_STABILIZE:  stabilize_ms         = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $error("result beat with nothing expected: 0x%0h", got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("action_kind", 32'(want.action_kind), 32'(got.action_kind));
                    check_field("action_reason", 32'(want.action_reason),
                                32'(got.action_reason));
                    check_field("action_target", 32'(want.action_target),
                                32'(got.action_target));
                    check_field("action_parent", 32'(want.action_parent),
                                32'(got.action_parent));
                    check_field("state_now", 32'(want.state_now), 32'(got.state_now));
                    check_field("failovers_done", want.failovers_done, got.failovers_done);
                    check_field("preferred_attempts", want.preferred_attempts,
                                got.preferred_attempts);
                    check_field("preferred_successes", want.preferred_successes,
                                got.preferred_successes);
                    check_field("preferred_misses", want.preferred_misses,
                                got.preferred_misses);
                    check_field("last_outcome", 32'(want.last_outcome),
                                32'(got.last_outcome));
                    check_field("last_target", 32'(want.last_target), 32'(got.last_target));
                    check_field("outcome_events", want.outcome_events, got.outcome_events);
                end
            end
            if (s_valid && s_ready) begin
                advance_controller(s_data, want);
                expected_results.push_back(want);
            end
        end
        fail_count   <= mismatches;
        results_owed <= expected_results.size();
    end

endmodule

### tb/sv/tb_parent_failover_state_machine_top.sv
// ============================================================================
// tb_parent_failover_state_machine_top
// Stimulus and verdict for the parent failover controller.
// A directed walk through every mode and action at reset intervals, then
// phases of random events under several interval settings and idling mixes.
// Checking is done by pfsm_result_checker sitting beside the block.
// ============================================================================
module tb_parent_failover_state_machine_top;
    import pfsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on any channel before the run is called hung.
    // Longest legal quiet stretch is the HOLD_OFF result hold-off.
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLD_OFF    = 150;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned IN_W        = $bits(in_t);

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int unsigned          fail_count;
    int unsigned          results_owed;

    // stimulus knobs, changed per phase
    int unsigned          idle_pct  = 0;   // sender idle, per cent of cycles
    int unsigned          stall_pct = 0;   // receiver stalled, per cent of cycles
    int unsigned          tick_max  = 20;  // typical clock advance between events
    logic [31:0]          sim_now   = '0;  // event time cursor
    logic [15:0]          addr_pool[4];
    logic [15:0]          sticky_standby = 16'h0001;
    bit                   hold_req  = 1'b0; // toggled to ask for a result hold-off

    int unsigned          quiet_cycles = 0;

    parent_failover_state_machine_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfsm_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side. Random stalls at stall_pct; a toggle of hold_req buys one
    // long hold-off, counted here, so the two stages fill and s_ready drops.
    always @(posedge aclk) begin
        int unsigned hold_left;
        bit          hold_seen;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            hold_seen = 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req != hold_seen) begin
            m_ready   <= 1'b0;
            hold_seen = hold_req;
            hold_left = HOLD_OFF;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hang detector: any beat on any channel resets the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** parent_failover_state_machine_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one event beat. Idle cycles come first, valid low; once valid is
    // raised it stays up until the beat is taken. Valid is left high on
    // return so back-to-back beats never lower and raise it in one step.
    task automatic send_event(input in_t ev);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Directed beat: flags are {attached, standby_ok, health_fail, degrade}.
    task automatic drive_event(input logic [31:0] now, input logic [3:0] flags,
                               input logic [15:0] par, input logic [15:0] sbp);
        in_t ev;
        ev.now_ms          = now;
        ev.attached_child  = flags[3];
        ev.standby_ok      = flags[2];
        ev.health_fail     = flags[1];
        ev.health_degrade  = flags[0];
        ev.attached_parent = par;
        ev.standby_parent  = sbp;
        send_event(ev);
    endtask

    // Register write; cfg_valid stays up for a following write, the caller
    // lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Stop offering and wait until every predicted result beat has come back.
    // The first edge lets the checker count a beat taken on the last edge.
    task automatic settle_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return $urandom_range(1, 100);
            2:       return $urandom;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Mostly plausible event streams: time moves forward by small steps so the
    // interval checks trip, attach is usually up, the standby address is
    // sticky and the attached parent often matches it, so preferred
    // reattaches succeed as well as miss. A slice of pure noise on top.
    function automatic in_t make_event();
        in_t         ev;
        int unsigned pick;
        logic [31:0] step;
        pick = $urandom_range(99);
        if (pick < 8) begin
            ev = IN_W'({$urandom, $urandom, $urandom});
            return ev;
        end
        pick = $urandom_range(99);
        if (pick < 10)      step = 32'd0;
        else if (pick < 87) step = $urandom_range(tick_max);
        else if (pick < 92) step = tick_max * $urandom_range(2, 6);
        else if (pick < 95) step = 32'hffff_ffff;   // lands one short of a full wrap
        else                step = $urandom;
        sim_now = sim_now + step;
        if ($urandom_range(99) < 20)
            sticky_standby = addr_pool[2'($urandom_range(3))];
        ev.now_ms         = sim_now;
        ev.attached_child = ($urandom_range(99) < 88);
        ev.standby_ok     = ($urandom_range(99) < 70);
        ev.health_fail    = ($urandom_range(99) < 12);
        ev.health_degrade = ($urandom_range(99) < 45);
        ev.standby_parent = sticky_standby;
        pick = $urandom_range(99);
        if (pick < 55)      ev.attached_parent = sticky_standby;
        else if (pick < 75) ev.attached_parent = addr_pool[2'($urandom_range(3))];
        else if (pick < 82) ev.attached_parent = NO_ADDR;
        else if (pick < 89) ev.attached_parent = ALT_NO_ADDR;
        else                ev.attached_parent = 16'($urandom);
        return ev;
    endfunction

    // One phase: write all intervals plus a dropped out-of-range index, set
    // the idling mix, run random events, then drain.
    task automatic run_phase(input logic [31:0] hold, input logic [31:0] elig,
                             input logic [31:0] pref, input logic [31:0] stab,
                             input int unsigned tick, input int unsigned idle,
                             input int unsigned stall, input int unsigned beats,
                             input bit squeeze);
        int unsigned n;
        write_reg(REG_HOLD_DOWN, hold);
        write_reg(REG_ELIG_DELAY, elig);
        write_reg(REG_PREF_TMO, pref);
        write_reg(REG_STABILIZE, stab);
        write_reg(CFG_IDX_W'($urandom_range(4, 15)), $urandom);
        cfg_valid <= 1'b0;
        tick_max  = tick;
        idle_pct  = idle;
        stall_pct = stall;
        addr_pool[0] = 16'($urandom);
        addr_pool[1] = 16'($urandom);
        addr_pool[2] = 16'h0000;
        addr_pool[3] = ($urandom_range(1)) ? ALT_NO_ADDR : NO_ADDR;
        if (squeeze)
            hold_req <= ~hold_req;
        for (n = 0; n < beats; n++)
            send_event(make_event());
        settle_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk at reset intervals (30000/10000/15000/30000).
        drive_event(32'd0,      4'b0000, NO_ADDR, 16'h0000); // bootstrap -> attaching
        drive_event(32'd200,    4'b1000, NO_ADDR, 16'h0000); // attached, no standby
        drive_event(32'd300,    4'b1100, NO_ADDR, 16'h0000); // standby warm
        drive_event(32'd400,    4'b1101, NO_ADDR, 16'h0000); // degraded inside hold-down
        drive_event(32'd40000,  4'b1101, NO_ADDR, 16'h0000); // eligible
        drive_event(32'd45000,  4'b1101, NO_ADDR, 16'h0000); // not yet long enough
        drive_event(32'd50000,  4'b1101, NO_ADDR, 16'h0000); // triggered on the boundary
        drive_event(32'd50001,  4'b1100, NO_ADDR, 16'h1234); // preferred reattach
        drive_event(32'd50002,  4'b1100, 16'h1234, 16'h1234); // reached target
        drive_event(32'd80002,  4'b1000, 16'h1234, 16'h1234); // stabilised, no standby
        drive_event(32'd80004,  4'b1010, 16'h1234, 16'h1234); // health fail after hold-down
        drive_event(32'd80005,  4'b0000, NO_ADDR, 16'h1234); // generic, no standby
        drive_event(32'd80006,  4'b1000, 16'h5555, 16'h1234); // attached -> stabilise
        drive_event(32'd110006, 4'b1100, 16'h5555, 16'h1234); // back to warm
        drive_event(32'd140010, 4'b1110, 16'h5555, 16'h1234); // triggered
        drive_event(32'd140011, 4'b0100, NO_ADDR, 16'habcd); // preferred to abcd
        drive_event(32'd140012, 4'b1100, 16'h0042, 16'habcd); // wrong parent: miss
        drive_event(32'd140013, 4'b0000, NO_ADDR, 16'habcd); // generic waits for attach
        drive_event(32'd140014, 4'b1000, 16'h0042, 16'habcd); // attached -> stabilise
        drive_event(32'd140015, 4'b0000, NO_ADDR, 16'habcd); // detached while settling
        drive_event(32'd140016, 4'b1100, 16'h0042, 16'habcd); // warm
        drive_event(32'd170020, 4'b1110, 16'h0000, 16'hfffe); // triggered
        drive_event(32'd170021, 4'b0100, NO_ADDR, ALT_NO_ADDR); // preferred to fffe
        drive_event(32'd185021, 4'b0000, NO_ADDR, ALT_NO_ADDR); // detached timeout
        drive_event(32'd185022, 4'b1000, 16'h0042, ALT_NO_ADDR); // stabilise
        drive_event(32'hffff_ffff, 4'b1111, NO_ADDR, NO_ADDR); // top of time, warm
        drive_event(32'd1,      4'b1110, NO_ADDR, 16'h0000); // wrapped, triggered
        drive_event(32'd2,      4'b0100, NO_ADDR, 16'h0000); // preferred to 0000
        drive_event(32'd15002,  4'b1000, NO_ADDR, 16'h0000); // attached-unknown timeout
        settle_results();

        // Short intervals, no idling at all.
        run_phase(32'd20, 32'd10, 32'd15, 32'd20, 25, 0, 0, 400, 1'b0);
        // Zero intervals, sender mostly idle.
        run_phase(32'd0, 32'd0, 32'd0, 32'd0, 5, 84, 0, 300, 1'b0);
        // Small random intervals, receiver mostly stalled.
        run_phase($urandom_range(1, 60), $urandom_range(1, 60), $urandom_range(1, 60),
                  $urandom_range(1, 60), 60, 0, 84, 300, 1'b0);
        // Largest intervals: only a difference of exactly all-ones passes.
        run_phase(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  20, 19, 19, 250, 1'b0);
        // Back-pressure: long result hold-off while events keep coming.
        run_phase(32'd50, 32'd30, 32'd40, 32'd50, 60, 0, 0, 300, 1'b1);
        // Mixed settings, light receiver stalls.
        run_phase(pick_interval(), pick_interval(), pick_interval(), pick_interval(),
                  200, 0, 19, 400, 1'b0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("** parent_failover_state_machine_top: PASSED **");
        else
            $display("** parent_failover_state_machine_top: FAILED **");
        $finish;
    end

endmodule
